// File: hdl/trbs_pkg.sv
// ----------------------------------------------------------------------------
// trbs_pkg: shared constants and types for the thread scheduler
// Command and status codes, port widths and parameter defaults.
// ----------------------------------------------------------------------------
package trbs_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_WIDTH    = 8;

  localparam int CMD_W       = 3;
  localparam int ID_PORT_W   = 8;
  localparam int COUNT_PORT_W = 5;
  localparam int STATUS_W    = 2;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_ADD        = 3'd0;
  localparam cmd_t CMD_SCHED      = 3'd1;
  localparam cmd_t CMD_FINISH     = 3'd2;
  localparam cmd_t CMD_BLOCK      = 3'd3;
  localparam cmd_t CMD_NOTIFY     = 3'd4;
  localparam cmd_t CMD_NOTIFY_ALL = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

// File: hdl/thread_ready_blocked_scheduler_top.sv
// Sequence: start moves IDLE to EXEC; out_valid pulses in DONE. Add and refused commands
//   go straight to DONE, schedule or finish on a non-empty ready queue and notify pass POP
//   or MOVE first, block reruns EXEC as finish, and notify all loops MOVE back to EXEC.
// Throughput: one item at a time; busy drops the cycle after the strobe. A sequencer
//   drives registered reads of the two queue memories. The receiver cannot stall.
// Reset (rst_n low, synchronous): both queues empty, idle thread running.
// ----------------------------------------------------------------------------
// thread_ready_blocked_scheduler_top: round-robin thread scheduler
// Ready FIFO, blocked FIFO and running id, driven by a small sequencer.
// ----------------------------------------------------------------------------
module thread_ready_blocked_scheduler_top #(
  parameter int QUEUE_DEPTH = trbs_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_WIDTH    = trbs_pkg::DEF_ID_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  trbs_pkg::cmd_t                     in_command,
  input  logic [trbs_pkg::ID_PORT_W-1:0]     in_thread_id,
  output logic                               out_valid,
  output logic [trbs_pkg::ID_PORT_W-1:0]     out_running_id,
  output logic [trbs_pkg::COUNT_PORT_W-1:0]  out_ready_count,
  output logic [trbs_pkg::COUNT_PORT_W-1:0]  out_blocked_count,
  output trbs_pkg::status_t                  out_status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state_r, state_nxt;
  trbs_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [ID_WIDTH-1:0] tid_r, tid_nxt;
  trbs_pkg::status_t   status_r, status_nxt;
  logic [ID_WIDTH-1:0] current_r, current_nxt;
  logic [ID_WIDTH-1:0] prev_r, prev_nxt;
  logic                keep_r, keep_nxt;

  logic [PTR_W-1:0]    ready_head_r, ready_head_nxt;
  logic [CNT_W-1:0]    ready_fill_r, ready_fill_nxt;
  logic [PTR_W-1:0]    blocked_head_r, blocked_head_nxt;
  logic [CNT_W-1:0]    blocked_fill_r, blocked_fill_nxt;

  logic [ID_WIDTH-1:0] ready_mem [0:QUEUE_DEPTH-1];
  logic [ID_WIDTH-1:0] blocked_mem [0:QUEUE_DEPTH-1];
  logic [ID_WIDTH-1:0] ready_rdata_r, blocked_rdata_r;

  logic                ready_we, blocked_we;
  logic [ID_WIDTH-1:0] ready_wdata, blocked_wdata;
  logic [SUM_W-1:0]    ready_sum, blocked_sum;
  logic [PTR_W-1:0]    ready_tail, blocked_tail;
  logic [PTR_W-1:0]    ready_head_inc, blocked_head_inc;
  logic                ready_full, blocked_full;

  // tail = head + fill, wrapped once
  assign ready_sum    = SUM_W'(ready_head_r) + SUM_W'(ready_fill_r);
  assign blocked_sum  = SUM_W'(blocked_head_r) + SUM_W'(blocked_fill_r);
  assign ready_tail   = (ready_sum >= SUM_W'(QUEUE_DEPTH)) ?
                        PTR_W'(ready_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(ready_sum);
  assign blocked_tail = (blocked_sum >= SUM_W'(QUEUE_DEPTH)) ?
                        PTR_W'(blocked_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(blocked_sum);

  assign ready_head_inc   = (ready_head_r == PTR_W'(QUEUE_DEPTH - 1)) ?
                            '0 : ready_head_r + PTR_W'(1);
  assign blocked_head_inc = (blocked_head_r == PTR_W'(QUEUE_DEPTH - 1)) ?
                            '0 : blocked_head_r + PTR_W'(1);

  assign ready_full   = (ready_fill_r == CNT_W'(QUEUE_DEPTH));
  assign blocked_full = (blocked_fill_r == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    state_nxt        = state_r;
    cmd_nxt          = cmd_r;
    tid_nxt          = tid_r;
    status_nxt       = status_r;
    current_nxt      = current_r;
    prev_nxt         = prev_r;
    keep_nxt         = keep_r;
    ready_head_nxt   = ready_head_r;
    ready_fill_nxt   = ready_fill_r;
    blocked_head_nxt = blocked_head_r;
    blocked_fill_nxt = blocked_fill_r;
    ready_we         = 1'b0;
    ready_wdata      = prev_r;
    blocked_we       = 1'b0;
    blocked_wdata    = current_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_command;
          tid_nxt    = ID_WIDTH'(in_thread_id);
          status_nxt = trbs_pkg::ST_OK;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (cmd_r)
          trbs_pkg::CMD_ADD: begin
            if (ready_full) begin
              status_nxt = trbs_pkg::ST_FULL;
            end else begin
              ready_we       = 1'b1;
              ready_wdata    = tid_r;
              ready_fill_nxt = ready_fill_r + CNT_W'(1);
            end
          end
          trbs_pkg::CMD_SCHED, trbs_pkg::CMD_FINISH: begin
            if (ready_fill_r == '0) begin
              current_nxt = '0;
            end else begin
              // front read issued now, data lands for the pop state
              ready_head_nxt = ready_head_inc;
              ready_fill_nxt = ready_fill_r - CNT_W'(1);
              keep_nxt       = (cmd_r == trbs_pkg::CMD_SCHED) && (current_r != '0);
              prev_nxt       = current_r;
              state_nxt      = S_POP;
            end
          end
          trbs_pkg::CMD_BLOCK: begin
            if (blocked_full) begin
              status_nxt = trbs_pkg::ST_FULL;
            end else begin
              blocked_we       = 1'b1;
              blocked_fill_nxt = blocked_fill_r + CNT_W'(1);
              // continue as finish: schedule without putting it back
              cmd_nxt          = trbs_pkg::CMD_FINISH;
              state_nxt        = S_EXEC;
            end
          end
          trbs_pkg::CMD_NOTIFY, trbs_pkg::CMD_NOTIFY_ALL: begin
            if (blocked_fill_r == '0) begin
              status_nxt = (cmd_r == trbs_pkg::CMD_NOTIFY) ?
                           trbs_pkg::ST_EMPTY : trbs_pkg::ST_OK;
            end else if (ready_full) begin
              status_nxt = trbs_pkg::ST_FULL;
            end else begin
              blocked_head_nxt = blocked_head_inc;
              blocked_fill_nxt = blocked_fill_r - CNT_W'(1);
              state_nxt        = S_MOVE;
            end
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        current_nxt = ready_rdata_r;
        if (keep_r) begin
          ready_we       = 1'b1;
          ready_fill_nxt = ready_fill_r + CNT_W'(1);
        end
        state_nxt = S_DONE;
      end
      S_MOVE: begin
        ready_we       = 1'b1;
        ready_wdata    = blocked_rdata_r;
        ready_fill_nxt = ready_fill_r + CNT_W'(1);
        // notify all loops back until blocked empties or ready fills
        state_nxt      = (cmd_r == trbs_pkg::CMD_NOTIFY_ALL) ? S_EXEC : S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      current_r      <= '0;
      keep_r         <= 1'b0;
      ready_head_r   <= '0;
      ready_fill_r   <= '0;
      blocked_head_r <= '0;
      blocked_fill_r <= '0;
    end else begin
      state_r        <= state_nxt;
      current_r      <= current_nxt;
      keep_r         <= keep_nxt;
      ready_head_r   <= ready_head_nxt;
      ready_fill_r   <= ready_fill_nxt;
      blocked_head_r <= blocked_head_nxt;
      blocked_fill_r <= blocked_fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    tid_r    <= tid_nxt;
    status_r <= status_nxt;
    prev_r   <= prev_nxt;
  end

  // queue memories: one write port at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (ready_we) begin
      ready_mem[ready_tail] <= ready_wdata;
    end
    ready_rdata_r <= ready_mem[ready_head_r];
  end

  always_ff @(posedge clk) begin
    if (blocked_we) begin
      blocked_mem[blocked_tail] <= blocked_wdata;
    end
    blocked_rdata_r <= blocked_mem[blocked_head_r];
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = (state_r == S_DONE);
  assign out_running_id    = trbs_pkg::ID_PORT_W'(current_r);
  assign out_ready_count   = trbs_pkg::COUNT_PORT_W'(ready_fill_r);
  assign out_blocked_count = trbs_pkg::COUNT_PORT_W'(blocked_fill_r);
  assign out_status        = status_r;

endmodule

// File: hdl/trbs_checker.sv
// ----------------------------------------------------------------------------
// trbs_checker: port-level checks for the thread scheduler
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module trbs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [trbs_pkg::COUNT_PORT_W-1:0] out_blocked_count,
  input trbs_pkg::status_t                 out_status
);

  // strobe only while an item is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while not busy");

  // an accepted item holds the block busy and gives no result the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted item did not occupy the block");

  // one result per item
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // the block goes idle right after its result
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("still busy after result");

  // notify refused as empty only when the blocked queue is empty
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == trbs_pkg::ST_EMPTY)) |-> (out_blocked_count == '0))
    else $error("empty status with threads blocked");

endmodule

bind thread_ready_blocked_scheduler_top trbs_checker u_trbs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_blocked_count (out_blocked_count),
  .out_status        (out_status)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the round-robin thread scheduler
// Drives scheduler commands over the start/busy handshake, tracks the ready
// queue, blocked queue and running thread in its own scoreboard, and checks
// every strobed result field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int             QDEPTH      = trbs_pkg::DEF_QUEUE_DEPTH;
  localparam int             STALL_LIMIT = 500;
  localparam int             MAX_GAP     = 40;
  localparam int             END_DRAIN   = 40;
  localparam int             PHASE_ITEMS = 457;
  localparam int             MIX_SPAN    = 60;
  localparam trbs_pkg::cmd_t CMD_SPARE6  = 3'd6;
  localparam trbs_pkg::cmd_t CMD_SPARE7  = 3'd7;

  typedef struct packed {
    logic [trbs_pkg::ID_PORT_W-1:0]    running_id;
    logic [trbs_pkg::COUNT_PORT_W-1:0] ready_count;
    logic [trbs_pkg::COUNT_PORT_W-1:0] blocked_count;
    trbs_pkg::status_t                 status;
  } sched_result_t;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  trbs_pkg::cmd_t                    in_command;
  logic [trbs_pkg::ID_PORT_W-1:0]    in_thread_id;
  logic                              out_valid;
  logic [trbs_pkg::ID_PORT_W-1:0]    out_running_id;
  logic [trbs_pkg::COUNT_PORT_W-1:0] out_ready_count;
  logic [trbs_pkg::COUNT_PORT_W-1:0] out_blocked_count;
  trbs_pkg::status_t                 out_status;

  // scoreboard copy of the scheduler state
  logic [trbs_pkg::ID_PORT_W-1:0] ready_ids[$];
  logic [trbs_pkg::ID_PORT_W-1:0] blocked_ids[$];
  logic [trbs_pkg::ID_PORT_W-1:0] running_now = '0;
  sched_result_t                  pending_results[$];
  int                             error_count  = 0;
  int                             stall_cycles = 0;

  thread_ready_blocked_scheduler_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_thread_id     (in_thread_id),
    .out_valid        (out_valid),
    .out_running_id   (out_running_id),
    .out_ready_count  (out_ready_count),
    .out_blocked_count(out_blocked_count),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Pop the next ready thread; an empty ready queue drops to the idle thread.
  function automatic void run_schedule(bit rotate);
    logic [trbs_pkg::ID_PORT_W-1:0] prev;
    prev = running_now;
    if (ready_ids.size() == 0) begin
      running_now = '0;
    end else begin
      running_now = ready_ids[0];
      ready_ids.delete(0);
      if (rotate && prev != '0) ready_ids = {ready_ids, prev};
    end
  endfunction

  function automatic sched_result_t apply_command(trbs_pkg::cmd_t cmd,
                                                  logic [trbs_pkg::ID_PORT_W-1:0] tid);
    sched_result_t     res;
    trbs_pkg::status_t st;
    st = trbs_pkg::ST_OK;
    case (cmd)
      trbs_pkg::CMD_ADD: begin
        if (ready_ids.size() >= QDEPTH) st = trbs_pkg::ST_FULL;
        else ready_ids = {ready_ids, tid};
      end
      trbs_pkg::CMD_SCHED:  run_schedule(1'b1);
      trbs_pkg::CMD_FINISH: run_schedule(1'b0);
      trbs_pkg::CMD_BLOCK: begin
        if (blocked_ids.size() >= QDEPTH) begin
          st = trbs_pkg::ST_FULL;
        end else begin
          blocked_ids = {blocked_ids, running_now};
          run_schedule(1'b0);
        end
      end
      trbs_pkg::CMD_NOTIFY: begin
        if (blocked_ids.size() == 0) begin
          st = trbs_pkg::ST_EMPTY;
        end else if (ready_ids.size() >= QDEPTH) begin
          st = trbs_pkg::ST_FULL;
        end else begin
          ready_ids = {ready_ids, blocked_ids[0]};
          blocked_ids.delete(0);
        end
      end
      trbs_pkg::CMD_NOTIFY_ALL: begin
        while (blocked_ids.size() > 0 && ready_ids.size() < QDEPTH) begin
          ready_ids = {ready_ids, blocked_ids[0]};
          blocked_ids.delete(0);
        end
        if (blocked_ids.size() > 0) st = trbs_pkg::ST_FULL;
      end
      default: ;
    endcase
    res.running_id    = running_now;
    res.ready_count   = trbs_pkg::COUNT_PORT_W'(ready_ids.size());
    res.blocked_count = trbs_pkg::COUNT_PORT_W'(blocked_ids.size());
    res.status        = st;
    return res;
  endfunction

  // Enter at a falling edge; leave at the falling edge after the item is taken.
  task automatic issue_command(trbs_pkg::cmd_t cmd, logic [trbs_pkg::ID_PORT_W-1:0] tid,
                               int idle_pct);
    int gap;
    gap = 0;
    while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      gap++;
      @(negedge clk);
    end
    start        <= 1'b1;
    in_command   <= cmd;
    in_thread_id <= tid;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results = {pending_results, apply_command(cmd, tid)};
    @(negedge clk);
  endtask

  function automatic trbs_pkg::cmd_t pick_command(bit filling);
    int r;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 40) return trbs_pkg::CMD_ADD;
      if (r < 65) return trbs_pkg::CMD_BLOCK;
      if (r < 78) return trbs_pkg::CMD_SCHED;
      if (r < 84) return trbs_pkg::CMD_FINISH;
      if (r < 91) return trbs_pkg::CMD_NOTIFY;
      if (r < 96) return trbs_pkg::CMD_NOTIFY_ALL;
    end else begin
      if (r < 12) return trbs_pkg::CMD_ADD;
      if (r < 22) return trbs_pkg::CMD_BLOCK;
      if (r < 37) return trbs_pkg::CMD_SCHED;
      if (r < 57) return trbs_pkg::CMD_FINISH;
      if (r < 77) return trbs_pkg::CMD_NOTIFY;
      if (r < 96) return trbs_pkg::CMD_NOTIFY_ALL;
    end
    return (r < 98) ? CMD_SPARE6 : CMD_SPARE7;
  endfunction

  task automatic test_idle_commands();
    issue_command(trbs_pkg::CMD_SCHED,      8'h00, 0);
    issue_command(trbs_pkg::CMD_FINISH,     8'hFF, 0);
    issue_command(trbs_pkg::CMD_NOTIFY,     8'h00, 0);
    issue_command(trbs_pkg::CMD_NOTIFY_ALL, 8'h00, 0);
    // blocking while idle queues the idle id
    issue_command(trbs_pkg::CMD_BLOCK,      8'h00, 0);
    issue_command(CMD_SPARE6,               8'h5A, 0);
    issue_command(CMD_SPARE7,               8'hA5, 0);
  endtask

  task automatic test_rotation_and_blocking();
    issue_command(trbs_pkg::CMD_ADD,        8'hFF, 0);
    issue_command(trbs_pkg::CMD_ADD,        8'h00, 0);
    issue_command(trbs_pkg::CMD_ADD,        8'h55, 0);
    issue_command(trbs_pkg::CMD_ADD,        8'hAA, 0);
    issue_command(trbs_pkg::CMD_SCHED,      8'h00, 0);
    // running thread rotates to the tail, except when it is the idle id
    issue_command(trbs_pkg::CMD_SCHED,      8'h00, 0);
    issue_command(trbs_pkg::CMD_SCHED,      8'h00, 0);
    issue_command(trbs_pkg::CMD_FINISH,     8'h00, 0);
    issue_command(trbs_pkg::CMD_BLOCK,      8'h00, 0);
    // empty ready queue: drop the running thread and go idle
    issue_command(trbs_pkg::CMD_SCHED,      8'h00, 0);
    issue_command(trbs_pkg::CMD_NOTIFY,     8'h00, 0);
    issue_command(trbs_pkg::CMD_NOTIFY_ALL, 8'h00, 0);
    issue_command(trbs_pkg::CMD_NOTIFY,     8'h00, 0);
    issue_command(trbs_pkg::CMD_FINISH,     8'h00, 0);
    issue_command(trbs_pkg::CMD_FINISH,     8'h00, 0);
    issue_command(trbs_pkg::CMD_BLOCK,      8'h00, 0);
  endtask

  // Alternate fill-heavy and drain-heavy stretches so both queues hit full and empty.
  task automatic test_random_mix(int idle_pct);
    bit filling;
    filling = 1'($urandom_range(1));
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % MIX_SPAN == 0 && i != 0) filling = ~filling;
      issue_command(pick_command(filling), trbs_pkg::ID_PORT_W'($urandom_range(255)),
                    idle_pct);
    end
  endtask

  task automatic report_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual running %0d status %0d",
                 $time, out_running_id, out_status);
        error_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        report_field("running_id",    want.running_id,    out_running_id);
        report_field("ready_count",   want.ready_count,   out_ready_count);
        report_field("blocked_count", want.blocked_count, out_blocked_count);
        report_field("status",        want.status,        out_status);
      end
    end
  end

  // Watchdog: count cycles with no item taken and no result seen.
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_command   = trbs_pkg::CMD_ADD;
    in_thread_id = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_commands();
    test_rotation_and_blocking();
    test_random_mix(0);
    test_random_mix(80);
    test_random_mix(0);
    test_random_mix(20);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
